// ===== hw/rtl/i2ra_pkg.sv =====
`default_nettype none

package i2ra_pkg;

    // Field widths of the input and result transactions.
    localparam int VALUE_W = 63;
    localparam int BASE_W  = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;

    // Default digit capacity of the store.
    localparam int MAX_DIGITS_DEF = 64;

    // The divider retires this many quotient bits per cycle.
    localparam int DIV_BITS_PER_CYCLE = 8;
    localparam int DIV_STEPS = (VALUE_W + DIV_BITS_PER_CYCLE - 1) / DIV_BITS_PER_CYCLE;
    localparam int DIV_PAD_W = DIV_STEPS * DIV_BITS_PER_CYCLE;

    localparam logic [BASE_W-1:0]  BASE_MIN     = BASE_W'(2);
    localparam logic [BASE_W-1:0]  BASE_MAX     = BASE_W'(36);
    localparam logic [DIGIT_W-1:0] DEC_DIGITS   = DIGIT_W'(10);
    localparam logic [CHAR_W-1:0]  ASCII_ZERO   = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  ASCII_NINE   = CHAR_W'(57);
    localparam logic [CHAR_W-1:0]  ASCII_LOWER_A = CHAR_W'(97);
    localparam logic [CHAR_W-1:0]  ASCII_LOWER_Z = CHAR_W'(122);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [BASE_W-1:0]  digit_base;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } out_item_t;

    // Bases outside the supported range are clamped to the nearest end.
    function automatic logic [BASE_W-1:0] sat_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        begin
            r = b;
            if (b < BASE_MIN)
            begin
                r = BASE_MIN;
            end
            else if (b > BASE_MAX)
            begin
                r = BASE_MAX;
            end
            return r;
        end
    endfunction

    // Digits 0..9 map to '0'..'9', digits 10..35 map to 'a'..'z'.
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        begin
            if (d >= DEC_DIGITS)
            begin
                c = CHAR_W'(d) - CHAR_W'(DEC_DIGITS) + ASCII_LOWER_A;
            end
            else
            begin
                c = CHAR_W'(d) + ASCII_ZERO;
            end
            return c;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/i2ra_stream_if.sv =====
`default_nettype none

interface i2ra_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/i2ra_ram.sv =====
`default_nettype none

module i2ra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/i2ra_divider.sv =====
`default_nettype none

// Restoring divider of the value by the base, several quotient bits a cycle.
module i2ra_divider (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [i2ra_pkg::VALUE_W-1:0]   dividend,
    input  wire logic [i2ra_pkg::BASE_W-1:0]    divisor,
    output logic                                done,
    output logic      [i2ra_pkg::VALUE_W-1:0]   quotient,
    output logic      [i2ra_pkg::DIGIT_W-1:0]   remainder
);
    import i2ra_pkg::*;

    localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    logic [DIV_PAD_W-1:0] dvd_reg, dvd_next;
    logic [DIGIT_W-1:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIV_PAD_W-1:0] sh_dvd;
    logic [DIGIT_W-1:0]   sh_rem;
    logic [DIGIT_W:0]     trial;
    logic                 ge;

    // One chunk of restoring division: shift in a dividend bit, subtract if it fits.
    always_comb
    begin
        sh_dvd = dvd_reg;
        sh_rem = rem_reg;
        trial  = '0;
        ge     = 1'b0;
        for (int i = 0; i < DIV_BITS_PER_CYCLE; i++)
        begin
            trial  = {sh_rem, sh_dvd[DIV_PAD_W-1]};
            ge     = (trial >= {1'b0, divisor});
            sh_rem = ge ? DIGIT_W'(trial - {1'b0, divisor}) : DIGIT_W'(trial);
            sh_dvd = {sh_dvd[DIV_PAD_W-2:0], ge};
        end
    end

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = DIV_PAD_W'(dividend);
            rem_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next  = sh_dvd;
            rem_next  = sh_rem;
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg[VALUE_W-1:0];
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/integer_to_radix_ascii.sv =====
`default_nettype none

// Channel   Dir   Payload                          Handshake
// in_ch     in    value[62:0], digit_base[5:0]     valid / ready
// out_ch    out   char_code[6:0], last_char        valid / ready
//
// A conversion of n digits is accepted while idle; each digit then passes through
// the shared divider (steps of 8 quotient bits each, then storing the remainder),
// and each character is output through a READ state and an EMIT state. The pace
// is set by the single divider and the store's read port.
// Reset returns the sequencer to idle at once; the digit store needs no clearing.
// The input is ready only while idle. A stalled output holds its character.

module integer_to_radix_ascii #(
    parameter int MAX_DIGITS = i2ra_pkg::MAX_DIGITS_DEF
) (
    input wire logic       clk,
    input wire logic       rst_n,
    i2ra_stream_if.sink    in_ch,
    i2ra_stream_if.source  out_ch
);
    import i2ra_pkg::*;

    localparam int ADDR_W = $clog2(MAX_DIGITS);
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_DIGITS);

    // Sequencer: IDLE waits for a transaction, DIV runs divisions until the
    // quotient is zero or the store is full, READ fetches a digit from the
    // store, EMIT presents it until the sink takes it.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_READ = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [BASE_W-1:0]  base_reg, base_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ADDR_W-1:0]  rd_idx_reg, rd_idx_next;

    logic               div_start;
    logic               div_done;
    logic [VALUE_W-1:0] div_dividend;
    logic [VALUE_W-1:0] div_quot;
    logic [DIGIT_W-1:0] div_rem;

    logic               wr_en;
    logic               rd_en;
    logic [DIGIT_W-1:0] rd_digit;

    logic [CNT_W-1:0]   cnt_inc;
    logic               more_digits;

    i2ra_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (base_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Remainders are stored least significant digit first and read back in
    // the opposite order.
    i2ra_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[ADDR_W-1:0]),
        .wr_data (div_rem),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_digit)
    );

    assign cnt_inc = cnt_reg + 1'b1;

    // The division always runs at least once, so a zero value yields one
    // digit of zero. It repeats while the quotient is nonzero and the store
    // still has room.
    assign more_digits = (div_quot != '0) && (cnt_inc < CNT_LIMIT);

    always_comb
    begin
        state_next   = state_reg;
        base_next    = base_reg;
        cnt_next     = cnt_reg;
        rd_idx_next  = rd_idx_reg;
        div_start    = 1'b0;
        div_dividend = div_quot;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    div_start    = 1'b1;
                    div_dividend = in_ch.payload.value;
                    base_next    = sat_base(in_ch.payload.digit_base);
                    cnt_next     = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_inc;
                    if (more_digits)
                    begin
                        div_start = 1'b1;
                    end
                    else
                    begin
                        // The digit just written is the most significant one.
                        rd_idx_next = cnt_reg[ADDR_W-1:0];
                        state_next  = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_ch.ready)
                begin
                    if (rd_idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg - 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
    end

    assign in_ch.ready                = (state_reg == ST_IDLE);
    assign out_ch.valid               = (state_reg == ST_EMIT);
    assign out_ch.payload.char_code   = digit_to_ascii(rd_digit);
    assign out_ch.payload.last_char   = (rd_idx_reg == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/i2ra_checker.sv =====
`default_nettype none

module i2ra_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire i2ra_pkg::out_item_t  out_payload
);
    import i2ra_pkg::*;

    // A new transaction is never taken while a character is on offer.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a character is presented");

    // The block is busy for at least the cycle after it takes a transaction.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after an accepted transaction");

    // Every character is a lower-case radix digit.
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_payload.char_code >= ASCII_ZERO &&
                        out_payload.char_code <= ASCII_NINE) ||
                       (out_payload.char_code >= ASCII_LOWER_A &&
                        out_payload.char_code <= ASCII_LOWER_Z)))
        else $error("character outside the digit alphabet");

    // Once the final character is taken the block is idle again.
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_payload.last_char) |=> (in_ready && !out_valid))
        else $error("block not idle after the final character");

    // A stalled character holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_payload)))
        else $error("stalled character changed");

endmodule

bind integer_to_radix_ascii i2ra_checker u_i2ra_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_payload (out_ch.payload)
);

`default_nettype wire
